// ===== rtl/pdw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the PD wheel drive unit.
package pdw_pkg;

  localparam int GAIN_W       = 32;
  localparam int DIST_TOL_W   = 24;
  localparam int ANG_TOL_W    = 19;
  localparam int ANGLE_W      = 20;
  localparam int ANGLE_FRAC_W = 16;
  localparam int DRIVE_W      = 7;
  localparam int CFG_ADDR_W   = 3;
  localparam int OUT_DATA_W   = 16;

  localparam logic [5:0] DRIVE_MAX = 6'd63;
  localparam logic [5:0] LINE_MIN  = 6'd15;
  localparam logic [5:0] TURN_MIN  = 6'd18;

  // Register reset values
  localparam logic [GAIN_W-1:0]     LINE_KP_RST  = 32'd1007;
  localparam logic [GAIN_W-1:0]     LINE_KD_RST  = 32'd1007;
  localparam logic [GAIN_W-1:0]     TURN_KP_RST  = 32'd335544320;
  localparam logic [GAIN_W-1:0]     TURN_KD_RST  = 32'd83886080;
  localparam logic [DIST_TOL_W-1:0] DIST_TOL_RST = 24'd50000;
  localparam logic [ANG_TOL_W-1:0]  ANG_TOL_RST  = 19'd2294;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LINE_KP  = 3'd0,
    CFG_LINE_KD  = 3'd1,
    CFG_TURN_KP  = 3'd2,
    CFG_TURN_KD  = 3'd3,
    CFG_DIST_TOL = 3'd4,
    CFG_ANG_TOL  = 3'd5
  } pdw_cfg_idx_t;

  typedef enum logic {
    OP_LINE = 1'b0,
    OP_TURN = 1'b1
  } pdw_op_t;

  typedef struct packed {
    logic [GAIN_W-1:0]     line_kp;
    logic [GAIN_W-1:0]     line_kd;
    logic [GAIN_W-1:0]     turn_kp;
    logic [GAIN_W-1:0]     turn_kd;
    logic [DIST_TOL_W-1:0] dist_tol;
    logic [ANG_TOL_W-1:0]  ang_tol;
  } pdw_gains_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pdw_q_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUMSQ,
    ST_ROOT,
    ST_PREP,
    ST_MKP,
    ST_MKD,
    ST_SUM,
    ST_OUT
  } pdw_state_t;

endpackage

// ===== rtl/pdw_front.sv =====
`timescale 1ns / 1ps
// Input stage: accept requests, take coordinate magnitudes, push to the queue.
module pdw_front #(
  parameter int POS_BITS = 24,
  parameter int DATA_W   = 72,
  parameter int ENT_W    = 69
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [DATA_W-1:0]         in_tdata,
  input  logic                      in_tuser,
  input  pdw_pkg::pdw_q_stat_t      q_stat,
  output logic                      q_push,
  output logic [ENT_W-1:0]          q_wdata
);

  logic                           fv_r;
  logic                           fv_nxt;
  logic [ENT_W-1:0]               ent_r;
  logic [POS_BITS-1:0]            dx;
  logic [POS_BITS-1:0]            dy;
  logic [pdw_pkg::ANGLE_W-1:0]    ae;
  logic [POS_BITS-1:0]            mx;
  logic [POS_BITS-1:0]            my;
  logic                           accept;

  assign dx = in_tdata[POS_BITS-1:0];
  assign dy = in_tdata[2*POS_BITS-1:POS_BITS];
  assign ae = in_tdata[2*POS_BITS+pdw_pkg::ANGLE_W-1:2*POS_BITS];

  // Magnitude of the most negative code reads correctly as unsigned.
  assign mx = dx[POS_BITS-1] ? (~dx + 1'b1) : dx;
  assign my = dy[POS_BITS-1] ? (~dy + 1'b1) : dy;

  assign q_push    = fv_r && !q_stat.full;
  assign in_tready = !fv_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign q_wdata   = ent_r;

  always_comb begin
    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (q_push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r <= {ae, my, mx, in_tuser};
    end
  end

endmodule

// ===== rtl/pdw_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the input stage and the sequencer.
module pdw_queue #(
  parameter int ENT_W = 69
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [ENT_W-1:0]     wdata,
  input  logic                 pop,
  output logic [ENT_W-1:0]     rdata,
  output pdw_pkg::pdw_q_stat_t stat
);

  logic [ENT_W-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/pdw_back.sv =====
`timescale 1ns / 1ps
// Sequencer: square root, shared gain multiplier, saturation and result register.
module pdw_back #(
  parameter int POS_BITS       = 24,
  parameter int GAIN_FRAC_BITS = 24,
  parameter int ENT_W          = 69
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pdw_pkg::pdw_gains_t                gains,
  input  pdw_pkg::pdw_q_stat_t               q_stat,
  input  logic [ENT_W-1:0]                   q_rdata,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pdw_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser
);

  localparam int AW    = pdw_pkg::ANGLE_W;
  localparam int MB    = (POS_BITS > AW + 1) ? POS_BITS : AW + 1;
  localparam int PW    = pdw_pkg::GAIN_W + MB;
  localparam int RW    = 2 * POS_BITS;
  localparam int CNT_W = $clog2(POS_BITS);
  localparam int SH_L  = GAIN_FRAC_BITS;
  localparam int SH_T  = GAIN_FRAC_BITS + pdw_pkg::ANGLE_FRAC_W;

  pdw_pkg::pdw_state_t state_r, state_nxt;

  logic                    op_r;
  logic [POS_BITS-1:0]     mx_r;
  logic [POS_BITS-1:0]     my_r;
  logic [AW-1:0]           ae_r;
  logic [PW-1:0]           prod_r;
  logic [PW-1:0]           acc_r;
  logic [RW-1:0]           rad_r;
  logic [POS_BITS+1:0]     rem_r;
  logic [POS_BITS-1:0]     root_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [MB-1:0]           em_r;
  logic                    esgn_r;
  logic [MB-1:0]           dm_r;
  logic                    dsgn_r;
  logic                    done_r;
  logic [POS_BITS-1:0]     last_dist_r;
  logic [AW-1:0]           last_ang_r;
  logic [PW:0]             sum_mag_r;
  logic                    sum_neg_r;
  logic                    out_valid_r;
  logic [pdw_pkg::DRIVE_W-1:0] right_r;
  logic [pdw_pkg::DRIVE_W-1:0] left_r;
  logic                    done_out_r;

  // control from the output decode
  logic                    out_free;
  logic                    out_load;
  logic [pdw_pkg::GAIN_W-1:0] mul_a;
  logic [MB-1:0]           mul_b;

  // root step
  logic [POS_BITS+3:0]     rem_sh;
  logic [POS_BITS+3:0]     trial;
  logic                    root_ge;

  // error preparation
  logic [POS_BITS:0]       dd_l;
  logic [AW:0]             dd_t;
  logic [AW-1:0]           ae_mag;
  logic [MB-1:0]           em_c;
  logic                    esgn_c;
  logic [MB-1:0]           dm_c;
  logic                    dsgn_c;
  logic                    done_c;

  // signed sum
  logic [PW:0]             s_add;
  logic [PW:0]             s_diff;
  logic                    an;
  logic                    bn;
  logic [PW:0]             mag_c;
  logic                    neg_c;

  // shaping
  logic [PW:0]             q_full;
  logic                    q_big;
  logic                    q_zero;
  logic [5:0]              lvl6;
  logic [5:0]              lvl_min;
  logic [5:0]              lvl;
  logic                    neg_eff;
  logic [pdw_pkg::DRIVE_W-1:0] right_c;
  logic [pdw_pkg::DRIVE_W-1:0] left_c;

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pdw_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (q_rdata[0] == pdw_pkg::OP_TURN) ? pdw_pkg::ST_PREP : pdw_pkg::ST_SQX;
        end
      end
      pdw_pkg::ST_SQX:   state_nxt = pdw_pkg::ST_SQY;
      pdw_pkg::ST_SQY:   state_nxt = pdw_pkg::ST_SUMSQ;
      pdw_pkg::ST_SUMSQ: state_nxt = pdw_pkg::ST_ROOT;
      pdw_pkg::ST_ROOT: begin
        if (cnt_r == '0) begin
          state_nxt = pdw_pkg::ST_PREP;
        end
      end
      pdw_pkg::ST_PREP:  state_nxt = done_c ? pdw_pkg::ST_OUT : pdw_pkg::ST_MKP;
      pdw_pkg::ST_MKP:   state_nxt = pdw_pkg::ST_MKD;
      pdw_pkg::ST_MKD:   state_nxt = pdw_pkg::ST_SUM;
      pdw_pkg::ST_SUM:   state_nxt = pdw_pkg::ST_OUT;
      pdw_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = pdw_pkg::ST_IDLE;
        end
      end
      default:           state_nxt = pdw_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop, result load, multiplier operands
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      pdw_pkg::ST_IDLE: q_pop = !q_stat.empty;
      pdw_pkg::ST_SQX: begin
        mul_a = pdw_pkg::GAIN_W'(mx_r);
        mul_b = MB'(mx_r);
      end
      pdw_pkg::ST_SQY: begin
        mul_a = pdw_pkg::GAIN_W'(my_r);
        mul_b = MB'(my_r);
      end
      pdw_pkg::ST_MKP: begin
        mul_a = op_r ? gains.turn_kp : gains.line_kp;
        mul_b = em_r;
      end
      pdw_pkg::ST_MKD: begin
        mul_a = op_r ? gains.turn_kd : gains.line_kd;
        mul_b = dm_r;
      end
      pdw_pkg::ST_OUT:  out_load = out_free;
      default: begin
      end
    endcase
  end

  // One root bit per cycle
  assign rem_sh  = {rem_r, rad_r[RW-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign root_ge = (rem_sh >= trial);

  // Error and error delta for either mode
  assign dd_l   = {1'b0, root_r} - {1'b0, last_dist_r};
  assign dd_t   = {ae_r[AW-1], ae_r} - {last_ang_r[AW-1], last_ang_r};
  assign ae_mag = ae_r[AW-1] ? (~ae_r + 1'b1) : ae_r;

  always_comb begin
    logic [POS_BITS:0] dl_mag;
    logic [AW:0]       dt_mag;
    dl_mag = dd_l[POS_BITS] ? (~dd_l + 1'b1) : dd_l;
    dt_mag = dd_t[AW] ? (~dd_t + 1'b1) : dd_t;
    if (op_r == pdw_pkg::OP_TURN) begin
      em_c   = MB'(ae_mag);
      esgn_c = ae_r[AW-1];
      dm_c   = MB'(dt_mag);
      dsgn_c = dd_t[AW];
      done_c = (ae_mag < AW'(gains.ang_tol));
    end else begin
      em_c   = MB'(root_r);
      esgn_c = 1'b0;
      dm_c   = MB'(dl_mag[POS_BITS-1:0]);
      dsgn_c = dd_l[POS_BITS];
      done_c = (32'(root_r) < 32'(gains.dist_tol));
    end
  end

  // kp*|e| (acc_r) and kd*|d| (prod_r) joined as sign and magnitude
  assign s_add  = {1'b0, acc_r} + {1'b0, prod_r};
  assign s_diff = {1'b0, acc_r} - {1'b0, prod_r};
  assign an     = esgn_r && (acc_r != '0);
  assign bn     = dsgn_r && (prod_r != '0);

  always_comb begin
    if (an == bn) begin
      mag_c = s_add;
      neg_c = an;
    end else if (!s_diff[PW]) begin
      mag_c = s_diff;
      neg_c = an;
    end else begin
      mag_c = ~s_diff + 1'b1;
      neg_c = bn;
    end
    if (mag_c == '0) begin
      neg_c = 1'b0;
    end
  end

  // Truncate, clamp, floor at the minimum level
  assign q_full  = op_r ? (sum_mag_r >> SH_T) : (sum_mag_r >> SH_L);
  assign q_big   = (q_full[PW:6] != '0);
  assign q_zero  = (q_full == '0);
  assign lvl6    = q_big ? pdw_pkg::DRIVE_MAX : q_full[5:0];
  assign lvl_min = op_r ? pdw_pkg::TURN_MIN : pdw_pkg::LINE_MIN;
  assign lvl     = (lvl6 < lvl_min) ? lvl_min : lvl6;

  always_comb begin
    if (!q_zero) begin
      neg_eff = sum_neg_r;
    end else if (op_r == pdw_pkg::OP_TURN) begin
      neg_eff = sum_neg_r || (sum_mag_r == '0);
    end else begin
      neg_eff = 1'b0;
    end
    right_c = neg_eff ? (~{1'b0, lvl} + 1'b1) : {1'b0, lvl};
    left_c  = op_r ? (~right_c + 1'b1) : right_c;
    if (done_r) begin
      right_c = '0;
      left_c  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdw_pkg::ST_IDLE;
      last_dist_r <= '0;
      last_ang_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pdw_pkg::ST_PREP) begin
        if (op_r == pdw_pkg::OP_TURN) begin
          last_ang_r <= ae_r;
        end else begin
          last_dist_r <= root_r;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a * mul_b);
    if (q_pop) begin
      op_r <= q_rdata[0];
      mx_r <= q_rdata[POS_BITS:1];
      my_r <= q_rdata[2*POS_BITS:POS_BITS+1];
      ae_r <= q_rdata[2*POS_BITS+AW:2*POS_BITS+1];
    end
    if (state_r == pdw_pkg::ST_SQY || state_r == pdw_pkg::ST_MKD) begin
      acc_r <= prod_r;
    end
    if (state_r == pdw_pkg::ST_SUMSQ) begin
      rad_r  <= RW'(acc_r + prod_r);
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNT_W'(POS_BITS - 1);
    end
    if (state_r == pdw_pkg::ST_ROOT) begin
      rad_r  <= rad_r << 2;
      rem_r  <= root_ge ? (POS_BITS + 2)'(rem_sh - trial) : rem_sh[POS_BITS+1:0];
      root_r <= {root_r[POS_BITS-2:0], root_ge};
      cnt_r  <= cnt_r - 1'b1;
    end
    if (state_r == pdw_pkg::ST_PREP) begin
      em_r   <= em_c;
      esgn_r <= esgn_c;
      dm_r   <= dm_c;
      dsgn_r <= dsgn_c;
      done_r <= done_c;
    end
    if (state_r == pdw_pkg::ST_SUM) begin
      sum_mag_r <= mag_c;
      sum_neg_r <= neg_c;
    end
    if (out_load) begin
      right_r    <= right_c;
      left_r     <= left_c;
      done_out_r <= done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, left_r, right_r};
  assign out_tuser  = done_out_r;

endmodule

// ===== rtl/pd_wheel_drive_unit.sv =====
`timescale 1ns / 1ps
// PD wheel drive unit: top level with configuration registers and assertions.
//
// Each input request carries one command: op in in_tuser (0 straight, 1 turn) and
// dx, dy, angle_error in in_tdata. Each request gives exactly one result: the right
// and left wheel drive levels in out_tdata and the done flag in out_tuser.
// Straight mode takes the integer distance sqrt(dx^2 + dy^2), turn mode the angle
// error; inside tolerance both wheels stop and done is set, otherwise the PD sum
// is truncated, clamped to +-63 and held at a minimum magnitude.
// Straight requests are slower than turn requests: the square root resolves one
// root bit per cycle. A request inside tolerance skips the multiplies and comes
// back sooner. One request is worked on at a time; a two-entry queue behind the
// input register lets up to three further requests be taken while one is in work.
// The user must write gains and tolerances through cfg_we/cfg_addr/cfg_wdata only
// while idle; the block itself does not enforce it.
// Reset (rst_n low, synchronous) loads the default gains, clears both stored
// errors and drops any request in flight. A stalled receiver holds the result in
// the output register; the sequencer then waits, and the queue fills before
// in_tready falls.
module pd_wheel_drive_unit #(
  parameter int POS_BITS       = 24,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata, lowest bit up: dx[POS_BITS], dy[POS_BITS], angle_error[20], zero fill
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((2*POS_BITS+20+7)/8)*8-1:0]    in_tdata,
  input  logic                                  in_tuser,   // op
  // out_tdata, lowest bit up: right_drive[7], left_drive[7], zero fill[2]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pdw_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tuser,  // done_res
  input  logic                                  cfg_we,
  input  logic [pdw_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [pdw_pkg::GAIN_W-1:0]            cfg_wdata
);

  localparam int DATA_W = ((2 * POS_BITS + 20 + 7) / 8) * 8;
  localparam int ENT_W  = 1 + 2 * POS_BITS + pdw_pkg::ANGLE_W;

  pdw_pkg::pdw_gains_t  gains_r;
  pdw_pkg::pdw_q_stat_t q_stat;
  logic                 q_push;
  logic                 q_pop;
  logic [ENT_W-1:0]     q_wdata;
  logic [ENT_W-1:0]     q_rdata;

  // Configuration registers; writes to unused indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.line_kp  <= pdw_pkg::LINE_KP_RST;
      gains_r.line_kd  <= pdw_pkg::LINE_KD_RST;
      gains_r.turn_kp  <= pdw_pkg::TURN_KP_RST;
      gains_r.turn_kd  <= pdw_pkg::TURN_KD_RST;
      gains_r.dist_tol <= pdw_pkg::DIST_TOL_RST;
      gains_r.ang_tol  <= pdw_pkg::ANG_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pdw_pkg::CFG_LINE_KP:  gains_r.line_kp  <= cfg_wdata;
        pdw_pkg::CFG_LINE_KD:  gains_r.line_kd  <= cfg_wdata;
        pdw_pkg::CFG_TURN_KP:  gains_r.turn_kp  <= cfg_wdata;
        pdw_pkg::CFG_TURN_KD:  gains_r.turn_kd  <= cfg_wdata;
        pdw_pkg::CFG_DIST_TOL: gains_r.dist_tol <= cfg_wdata[pdw_pkg::DIST_TOL_W-1:0];
        pdw_pkg::CFG_ANG_TOL:  gains_r.ang_tol  <= cfg_wdata[pdw_pkg::ANG_TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register and coordinate magnitudes
  pdw_front #(
    .POS_BITS (POS_BITS),
    .DATA_W   (DATA_W),
    .ENT_W    (ENT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Decouple request intake from the sequencer
  pdw_queue #(
    .ENT_W (ENT_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Root, PD sum, saturation and result register
  pdw_back #(
    .POS_BITS       (POS_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .ENT_W          (ENT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .gains      (gains_r),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // A done result stops both wheels.
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[13:0] == 14'd0)
    else $error("done result with nonzero drive");

  // A driving result moves the wheels alike or opposite, never at zero or -64.
  a_drive_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tdata[6:0] != 7'd0) && (out_tdata[6:0] != 7'h40) &&
      ((out_tdata[13:7] == out_tdata[6:0]) ||
       (out_tdata[13:7] == 7'(~out_tdata[6:0] + 7'd1))))
    else $error("malformed drive levels");

  // The queue never reports full and empty together, and no pop hits an empty queue.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty) && !(q_pop && q_stat.empty))
    else $error("queue status inconsistent");

endmodule

// ===== bench/pd_wheel_drive_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the PD wheel drive unit: directed plan, random phases, scoreboard.
module pd_wheel_drive_unit_tb;

  localparam int POS_W       = 24;
  localparam int GAIN_FRAC   = 24;
  localparam int IN_W        = ((2*POS_W+pdw_pkg::ANGLE_W+7)/8)*8;
  localparam int FILL_W      = IN_W - 2*POS_W - pdw_pkg::ANGLE_W;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 6;
  localparam int PHASE_REQS  = 200;
  localparam int HOLD_AT     = 150;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;    // straight requests are the slowest
  localparam logic [pdw_pkg::CFG_ADDR_W-1:0] CFG_SPARE_IDX = 3'd6;  // no register behind it
  // address field of request rows, not used
  localparam logic [pdw_pkg::CFG_ADDR_W-1:0] REQ_ADDR = pdw_pkg::CFG_LINE_KP;
  localparam pdw_pkg::pdw_op_t OP_LN = pdw_pkg::OP_LINE;
  localparam pdw_pkg::pdw_op_t OP_TN = pdw_pkg::OP_TURN;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  // One drive result: right and left levels and the done flag
  typedef struct packed {
    logic [pdw_pkg::DRIVE_W-1:0] right;
    logic [pdw_pkg::DRIVE_W-1:0] left;
    logic                        done;
  } drive_t;

  // One row of the directed plan: either a request or a register write.
  // Where fixed is set, right/left/done are the typed-in answer.
  typedef struct packed {
    row_kind_t                        kind;
    pdw_pkg::pdw_op_t                 op;
    int                               dx;
    int                               dy;
    int                               ang;
    logic [pdw_pkg::CFG_ADDR_W-1:0]   addr;
    logic [pdw_pkg::GAIN_W-1:0]       val;
    logic                             fixed;
    int                               right;
    int                               left;
    logic                             done;
  } row_t;

  localparam int PLAN_ROWS = 32;
  localparam row_t PLAN [PLAN_ROWS] = '{
    // reset gains: zero distance and zero angle stop at once
    '{ROW_REQ, OP_LN, 0, 0, 0, REQ_ADDR, 0, 1'b1, 0, 0, 1'b1},
    '{ROW_REQ, OP_TN, 0, 0, 0, REQ_ADDR, 0, 1'b1, 0, 0, 1'b1},
    // largest distances saturate both wheels forward
    '{ROW_REQ, OP_LN, 8388607, -8388608, -524288, REQ_ADDR, 0, 1'b1, 63, 63, 1'b0},
    '{ROW_REQ, OP_LN, -8388608, -8388608, 524287, REQ_ADDR, 0, 1'b1, 63, 63, 1'b0},
    // falling distance pulls the derivative term negative
    '{ROW_REQ, OP_LN, 8388607, 0, 0, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0},
    // exactly at and just inside the distance tolerance
    '{ROW_REQ, OP_LN, 50000, 0, 0, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_LN, -49999, 0, 0, REQ_ADDR, 0, 1'b1, 0, 0, 1'b1},
    '{ROW_REQ, OP_LN, 30000, 40000, 0, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0},
    // angle extremes: wheels opposite and saturated
    '{ROW_REQ, OP_TN, -1, 5, 411775, REQ_ADDR, 0, 1'b1, 63, -63, 1'b0},
    '{ROW_REQ, OP_TN, 7, -1, -411775, REQ_ADDR, 0, 1'b1, -63, 63, 1'b0},
    // at and just inside the angle tolerance, then the turn minimum
    '{ROW_REQ, OP_TN, 0, 0, 2294, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_TN, 0, 0, -2293, REQ_ADDR, 0, 1'b1, 0, 0, 1'b1},
    '{ROW_REQ, OP_TN, 0, 0, 2300, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0},
    // angle field outside the nominal range
    '{ROW_REQ, OP_TN, 0, 0, -524288, REQ_ADDR, 0, 1'b1, -63, 63, 1'b0},
    '{ROW_REQ, OP_TN, 0, 0, 524287, REQ_ADDR, 0, 1'b1, 63, -63, 1'b0},
    // zero turn gains: an exact zero sum turns negative
    '{ROW_CFG, OP_LN, 0, 0, 0, pdw_pkg::CFG_TURN_KP, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_CFG, OP_LN, 0, 0, 0, pdw_pkg::CFG_TURN_KD, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_TN, 0, 0, 5000, REQ_ADDR, 0, 1'b1, -18, 18, 1'b0},
    // tiny turn sum: sign of the untruncated sum decides
    '{ROW_CFG, OP_LN, 0, 0, 0, pdw_pkg::CFG_TURN_KD, 1, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_TN, 0, 0, 6000, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_TN, 0, 0, -7000, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0},
    // zero straight level always becomes forward minimum
    '{ROW_CFG, OP_LN, 0, 0, 0, pdw_pkg::CFG_LINE_KP, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_CFG, OP_LN, 0, 0, 0, pdw_pkg::CFG_LINE_KD, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_LN, 100000, 0, 0, REQ_ADDR, 0, 1'b1, 15, 15, 1'b0},
    '{ROW_CFG, OP_LN, 0, 0, 0, pdw_pkg::CFG_LINE_KD, 1, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_LN, 90000, 0, 0, REQ_ADDR, 0, 1'b1, 15, 15, 1'b0},
    // zero tolerances: even zero error drives
    '{ROW_CFG, OP_LN, 0, 0, 0, pdw_pkg::CFG_DIST_TOL, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_CFG, OP_LN, 0, 0, 0, pdw_pkg::CFG_ANG_TOL, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_LN, 0, 0, 0, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_TN, 0, 0, 0, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0},
    // write to an index with no register: ignored
    '{ROW_CFG, OP_LN, 0, 0, 0, CFG_SPARE_IDX, 32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0},
    '{ROW_REQ, OP_LN, 10, 0, 0, REQ_ADDR, 0, 1'b0, 0, 0, 1'b0}
  };

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [IN_W-1:0]                   in_tdata;
  logic                              in_tuser;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [pdw_pkg::OUT_DATA_W-1:0]    out_tdata;
  logic                              out_tuser;
  logic                              cfg_we;
  logic [pdw_pkg::CFG_ADDR_W-1:0]    cfg_addr;
  logic [pdw_pkg::GAIN_W-1:0]        cfg_wdata;

  // Mirror of the block: registers and the two stored errors
  pdw_pkg::pdw_gains_t gains_model;
  logic [POS_W-1:0]    last_dist_model;
  longint              last_angle_model;

  drive_t pending_drives [$];
  int     mismatches      = 0;
  int     results_checked = 0;
  int     send_idle_pct   = 0;
  int     recv_idle_pct   = 0;
  int     hold_left       = 0;
  bit     held_once       = 1'b0;
  int     cycle_count     = 0;

  pd_wheel_drive_unit #(
    .POS_BITS      (POS_W),
    .GAIN_FRAC_BITS(GAIN_FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pd_wheel_drive_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] mag64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Bitwise integer square root, floor of the exact root
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    logic [63:0] rem;
    root = '0;
    rem  = x;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // kp*e + kd*d as sign and magnitude, exact in 64 bits
  function automatic void pd_mix(input logic [pdw_pkg::GAIN_W-1:0] kp, input longint e,
                                 input logic [pdw_pkg::GAIN_W-1:0] kd, input longint d,
                                 output logic neg, output logic [63:0] mag);
    logic [63:0] a;
    logic [63:0] b;
    logic        an;
    logic        bn;
    a  = kp * mag64(e);
    b  = kd * mag64(d);
    an = (e < 0) && (a != 0);
    bn = (d < 0) && (b != 0);
    if (an == bn) begin
      neg = an;
      mag = a + b;
    end else if (a >= b) begin
      neg = an;
      mag = a - b;
    end else begin
      neg = bn;
      mag = b - a;
    end
    if (mag == 0) neg = 1'b0;
  endfunction

  // Work out the wheel drive for one request and advance the stored errors
  function automatic drive_t predict_drive(input pdw_pkg::pdw_op_t op,
                                           input logic signed [POS_W-1:0] dx,
                                           input logic signed [POS_W-1:0] dy,
                                           input logic signed [pdw_pkg::ANGLE_W-1:0] ang);
    drive_t      r;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] span;
    logic [63:0] mag;
    logic [63:0] q;
    longint      e;
    longint      d;
    logic        neg;
    int          lvl;
    r = '0;
    if (op == pdw_pkg::OP_LINE) begin
      mx   = mag64(longint'(dx));
      my   = mag64(longint'(dy));
      span = int_sqrt(mx * mx + my * my);
      d    = longint'(span) - longint'(last_dist_model);
      last_dist_model = span[POS_W-1:0];
      if (span < gains_model.dist_tol) begin
        r.done = 1'b1;
      end else begin
        pd_mix(gains_model.line_kp, longint'(span), gains_model.line_kd, d, neg, mag);
        q = mag >> GAIN_FRAC;
        if (q == 0) begin
          lvl = int'(pdw_pkg::LINE_MIN);
        end else begin
          if (q > pdw_pkg::DRIVE_MAX) q = pdw_pkg::DRIVE_MAX;
          if (q < pdw_pkg::LINE_MIN) q = pdw_pkg::LINE_MIN;
          lvl = neg ? -int'(q) : int'(q);
        end
        r.right = lvl[pdw_pkg::DRIVE_W-1:0];
        r.left  = lvl[pdw_pkg::DRIVE_W-1:0];
      end
    end else begin
      e = longint'(ang);
      d = e - last_angle_model;
      last_angle_model = e;
      if (mag64(e) < gains_model.ang_tol) begin
        r.done = 1'b1;
      end else begin
        pd_mix(gains_model.turn_kp, e, gains_model.turn_kd, d, neg, mag);
        q = mag >> (GAIN_FRAC + pdw_pkg::ANGLE_FRAC_W);
        if (q == 0) begin
          // truncated to nothing: the exact sum picks the direction
          lvl = (!neg && mag != 0) ? int'(pdw_pkg::TURN_MIN) : -int'(pdw_pkg::TURN_MIN);
        end else begin
          if (q > pdw_pkg::DRIVE_MAX) q = pdw_pkg::DRIVE_MAX;
          if (q < pdw_pkg::TURN_MIN) q = pdw_pkg::TURN_MIN;
          lvl = neg ? -int'(q) : int'(q);
        end
        r.right = lvl[pdw_pkg::DRIVE_W-1:0];
        lvl     = -lvl;
        r.left  = lvl[pdw_pkg::DRIVE_W-1:0];
      end
    end
    return r;
  endfunction

  // Offer one request, hold it until taken, then queue what it should produce.
  // Call right after posedge clk.
  task automatic offer(input pdw_pkg::pdw_op_t op, input int dx, input int dy,
                       input int ang, input logic fixed, input drive_t fixed_drive);
    drive_t guess;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{FILL_W{1'b0}}, ang[pdw_pkg::ANGLE_W-1:0], dy[POS_W-1:0], dx[POS_W-1:0]};
    do @(posedge clk); while (!in_tready);
    guess = predict_drive(op, dx[POS_W-1:0], dy[POS_W-1:0], ang[pdw_pkg::ANGLE_W-1:0]);
    pending_drives.push_back(fixed ? fixed_drive : guess);
  endtask

  // Random request: mostly working-range errors, some near the tolerance, some raw bits
  task automatic offer_random();
    pdw_pkg::pdw_op_t op;
    int               dx;
    int               dy;
    int               ang;
    int               pick;
    op   = pdw_pkg::pdw_op_t'($urandom_range(1));
    pick = $urandom_range(9);
    dx   = $urandom;
    dy   = $urandom;
    ang  = $urandom;
    if (op == pdw_pkg::OP_LINE) begin
      if (pick < 6) begin
        dx = $urandom_range(240000) - 120000;
        dy = $urandom_range(240000) - 120000;
      end else if (pick < 8) begin
        dx = int'(gains_model.dist_tol) + $urandom_range(4) - 2;
        dy = $urandom_range(2);
        if ($urandom_range(1)) dx = -dx;
      end
    end else begin
      if (pick < 6) begin
        ang = $urandom_range(823550) - 411775;
      end else if (pick < 8) begin
        ang = int'(gains_model.ang_tol) + $urandom_range(4) - 2;
        if ($urandom_range(1)) ang = -ang;
      end
    end
    offer(op, dx, dy, ang, 1'b0, '0);
  endtask

  // Drop valid and let every outstanding request come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; leaves cfg_we high, the caller lowers it
  task automatic write_reg(input logic [pdw_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [pdw_pkg::GAIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    case (addr)
      pdw_pkg::CFG_LINE_KP:  gains_model.line_kp  = val;
      pdw_pkg::CFG_LINE_KD:  gains_model.line_kd  = val;
      pdw_pkg::CFG_TURN_KP:  gains_model.turn_kp  = val;
      pdw_pkg::CFG_TURN_KD:  gains_model.turn_kd  = val;
      pdw_pkg::CFG_DIST_TOL: gains_model.dist_tol = val[pdw_pkg::DIST_TOL_W-1:0];
      pdw_pkg::CFG_ANG_TOL:  gains_model.ang_tol  = val[pdw_pkg::ANG_TOL_W-1:0];
      default: ;
    endcase
  endtask

  // Program all six registers for one random phase
  task automatic load_phase_gains(input int phase);
    logic [pdw_pkg::GAIN_W-1:0] vals [6];
    case (phase)
      0: vals = '{pdw_pkg::LINE_KP_RST, pdw_pkg::LINE_KD_RST,
                  pdw_pkg::TURN_KP_RST, pdw_pkg::TURN_KD_RST,
                  pdw_pkg::GAIN_W'(pdw_pkg::DIST_TOL_RST),
                  pdw_pkg::GAIN_W'(pdw_pkg::ANG_TOL_RST)};
      // strongest gains, nothing counts as arrived
      1: vals = '{'1, '1, '1, '1, '0, '0};
      // no gain at all, widest tolerances (upper bits must be dropped)
      2: vals = '{'0, '0, '0, '0, '1, '1};
      3: vals = '{$urandom, $urandom, $urandom, $urandom,
                  $urandom_range(200000), $urandom_range(20000)};
      4: vals = '{$urandom_range(3000), $urandom_range(3000), $urandom_range(32'd671088640),
                  $urandom_range(32'd671088640), $urandom_range(100000), $urandom_range(5000)};
      default: vals = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endcase
    wait_idle();
    for (int i = 0; i < 6; i++) write_reg(pdw_pkg::pdw_cfg_idx_t'(i), vals[i]);
    if (phase == 0) write_reg(CFG_SPARE_IDX, '1);
    cfg_we <= 1'b0;
  endtask

  // Compare one taken result with the oldest pending drive
  task automatic check_drive();
    drive_t want;
    results_checked++;
    if (pending_drives.size() == 0) begin
      $error("result with no request pending: tdata %h done %b", out_tdata, out_tuser);
      mismatches++;
    end else begin
      want = pending_drives.pop_front();
      if (out_tdata[pdw_pkg::DRIVE_W-1:0] !== want.right) begin
        $error("right_drive: expected %0d, got %0d",
               $signed(want.right), $signed(out_tdata[pdw_pkg::DRIVE_W-1:0]));
        mismatches++;
      end
      if (out_tdata[2*pdw_pkg::DRIVE_W-1:pdw_pkg::DRIVE_W] !== want.left) begin
        $error("left_drive: expected %0d, got %0d",
               $signed(want.left), $signed(out_tdata[2*pdw_pkg::DRIVE_W-1:pdw_pkg::DRIVE_W]));
        mismatches++;
      end
      if (out_tuser !== want.done) begin
        $error("done_res: expected %0b, got %0b", want.done, out_tuser);
        mismatches++;
      end
    end
  endtask

  // Result side: check each taken result, then pick ready for the next edge.
  // Once, hold ready low for a long stretch so the block backs up into in_tready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_drive();
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!held_once && results_checked >= HOLD_AT) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    row_t   row;
    drive_t typed;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    gains_model      = '{pdw_pkg::LINE_KP_RST, pdw_pkg::LINE_KD_RST,
                         pdw_pkg::TURN_KP_RST, pdw_pkg::TURN_KD_RST,
                         pdw_pkg::DIST_TOL_RST, pdw_pkg::ANG_TOL_RST};
    last_dist_model  = '0;
    last_angle_model = 0;
    send_idle_pct    = 30;
    recv_idle_pct    = 57;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan
    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.addr, row.val);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        typed.right = row.right[pdw_pkg::DRIVE_W-1:0];
        typed.left  = row.left[pdw_pkg::DRIVE_W-1:0];
        typed.done  = row.done;
        offer(row.op, row.dx, row.dy, row.ang, row.fixed, typed);
      end
    end

    // Random phases: receiver-light, sender-light, then full speed
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_phase_gains(phase);
      repeat (PHASE_REQS) offer_random();
    end

    // Drain, then give the block time to show any stray result
    in_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("pd_wheel_drive_unit regression: pass");
    end else begin
      $display("pd_wheel_drive_unit regression: fail");
    end
    $finish;
  end

endmodule
